@@ hdl/lmhds_pkg.sv @@
// lmhds_pkg: shared types and constants for the deploy sequencer
// register map, reset values, phase codes and the configuration struct
// no dependencies
package lmhds_pkg;

   localparam int unsigned ADDR_WIDTH = 5;
   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned TICK_WIDTH = 17;

   // register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_UNLATCH_WAIT = 3'd0;
   localparam logic [2:0] REG_MOTOR_WAIT   = 3'd1;
   localparam logic [2:0] REG_DEPLOY_POWER = 3'd2;
   localparam logic [2:0] REG_IDLE_MOTOR   = 3'd3;
   localparam logic [2:0] REG_IDLE_LATCH   = 3'd4;
   localparam logic [2:0] REG_IDLE_HOTWIRE = 3'd5;

   localparam logic [15:0] RST_UNLATCH_WAIT = 16'd50;
   localparam logic [15:0] RST_MOTOR_WAIT   = 16'd50;
   localparam logic [14:0] RST_DEPLOY_POWER = 15'd16384;
   localparam logic [15:0] RST_IDLE_MOTOR   = 16'd0;
   localparam logic        RST_IDLE_LATCH   = 1'b1;
   localparam logic        RST_IDLE_HOTWIRE = 1'b0;

   localparam logic [1:0] PHASE_LATCHED    = 2'd0;
   localparam logic [1:0] PHASE_UNLATCHING = 2'd1;
   localparam logic [1:0] PHASE_MOTOR      = 2'd2;
   localparam logic [1:0] PHASE_CUT        = 2'd3;

   typedef struct packed {
      logic [15:0]        unlatch_wait_ticks;
      logic [15:0]        motor_wait_ticks;
      logic [14:0]        deploy_power;
      logic signed [15:0] idle_motor;
      logic               idle_latch;
      logic               idle_hotwire;
   } cfg_type;

endpackage

@@ hdl/lmhds_csr.sv @@
// lmhds_csr: configuration registers behind the apb-style port
// depends on lmhds_pkg
module lmhds_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lmhds_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [lmhds_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [lmhds_pkg::DATA_WIDTH-1:0] prdata,
   output logic                             pready,
   output lmhds_pkg::cfg_type               cfg
);
   import lmhds_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unlatch_wait_ticks <= RST_UNLATCH_WAIT;
         cfg_ff.motor_wait_ticks   <= RST_MOTOR_WAIT;
         cfg_ff.deploy_power       <= RST_DEPLOY_POWER;
         cfg_ff.idle_motor         <= RST_IDLE_MOTOR;
         cfg_ff.idle_latch         <= RST_IDLE_LATCH;
         cfg_ff.idle_hotwire       <= RST_IDLE_HOTWIRE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_UNLATCH_WAIT: cfg_ff.unlatch_wait_ticks <= pwdata[15:0];
            REG_MOTOR_WAIT:   cfg_ff.motor_wait_ticks   <= pwdata[15:0];
            REG_DEPLOY_POWER: cfg_ff.deploy_power       <= pwdata[14:0];
            REG_IDLE_MOTOR:   cfg_ff.idle_motor         <= pwdata[15:0];
            REG_IDLE_LATCH:   cfg_ff.idle_latch         <= pwdata[0];
            REG_IDLE_HOTWIRE: cfg_ff.idle_hotwire       <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_UNLATCH_WAIT: prdata = {16'd0, cfg_ff.unlatch_wait_ticks};
         REG_MOTOR_WAIT:   prdata = {16'd0, cfg_ff.motor_wait_ticks};
         REG_DEPLOY_POWER: prdata = {17'd0, cfg_ff.deploy_power};
         REG_IDLE_MOTOR:   prdata = {16'd0, cfg_ff.idle_motor};
         REG_IDLE_LATCH:   prdata = {31'd0, cfg_ff.idle_latch};
         REG_IDLE_HOTWIRE: prdata = {31'd0, cfg_ff.idle_hotwire};
         default:          prdata = '0;
      endcase
   end

endmodule

@@ hdl/lmhds_core.sv @@
// lmhds_core: input register, sequencer state machine and result register
// depends on lmhds_pkg
module lmhds_core (
   input  logic               clock,
   input  logic               reset,
   input  lmhds_pkg::cfg_type cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [1:0]  req_direction,
   input  logic               req_cut,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_motor,
   output logic               rsp_latch,
   output logic               rsp_hotwire,
   output logic [1:0]         rsp_phase
);
   import lmhds_pkg::*;

   typedef enum logic [1:0] {
      ST_LATCHED    = PHASE_LATCHED,
      ST_UNLATCHING = PHASE_UNLATCHING,
      ST_MOTOR      = PHASE_MOTOR,
      ST_CUT        = PHASE_CUT
   } mode_type;

   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

   // input stage
   logic              in_valid_ff;
   logic signed [1:0] in_dir_ff;
   logic              in_cut_ff;

   // sequencer state
   mode_type              mode_ff, mode_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;

   // result stage
   logic               out_valid_ff;
   logic signed [15:0] out_motor_ff, out_motor_in;
   logic               out_latch_ff, out_latch_in;
   logic               out_hot_ff, out_hot_in;
   logic [1:0]         out_phase_ff;

   logic out_free, advance, positive, negative, exceeded;
   logic [15:0] wait_sel;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign positive = (in_dir_ff == 2'sb01);
   assign negative = in_dir_ff[1];
   assign wait_sel = (mode_ff == ST_LATCHED) ? cfg.unlatch_wait_ticks
                                             : cfg.motor_wait_ticks;
   assign exceeded = (tick_ff > {1'b0, wait_sel});

   always_comb begin
      mode_in      = mode_ff;
      tick_in      = tick_ff;
      out_motor_in = cfg.idle_motor;
      out_latch_in = cfg.idle_latch;
      out_hot_in   = cfg.idle_hotwire;
      case (mode_ff)
         ST_LATCHED, ST_UNLATCHING: begin
            if (mode_ff == ST_UNLATCHING) begin
               out_latch_in = 1'b0;
            end
            if (positive) begin
               if (exceeded) begin
                  mode_in = (mode_ff == ST_LATCHED) ? ST_UNLATCHING : ST_MOTOR;
                  tick_in = '0;
               end else if (tick_ff != TICK_MAX) begin
                  tick_in = tick_ff + 1'b1;
               end
            end else begin
               tick_in = '0;
            end
         end
         ST_MOTOR: begin
            out_latch_in = 1'b0;
            if (in_cut_ff) begin
               mode_in = ST_CUT;
               tick_in = '0;
            end else if (positive) begin
               out_motor_in = {1'b0, cfg.deploy_power};
            end else if (negative) begin
               out_motor_in = -$signed({1'b0, cfg.deploy_power});
            end
         end
         ST_CUT: begin
            out_latch_in = 1'b0;
            if (!in_cut_ff) begin
               mode_in = ST_MOTOR;
               tick_in = '0;
            end else begin
               out_hot_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= ST_LATCHED;
         tick_ff      <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            mode_ff <= mode_in;
            tick_ff <= tick_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_dir_ff <= req_direction;
         in_cut_ff <= req_cut;
      end
      if (advance) begin
         out_motor_ff <= out_motor_in;
         out_latch_ff <= out_latch_in;
         out_hot_ff   <= out_hot_in;
         out_phase_ff <= mode_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_motor   = out_motor_ff;
   assign rsp_latch   = out_latch_ff;
   assign rsp_hotwire = out_hot_ff;
   assign rsp_phase   = out_phase_ff;

endmodule

@@ hdl/latch_motor_hotwire_deploy_sequencer.sv @@
// latch_motor_hotwire_deploy_sequencer: top level of the deploy sequencer
// depends on lmhds_pkg, lmhds_csr and lmhds_core
//
// each transfer on the req_ channel is one control-loop tick carrying the
// deploy direction and the cut request; each tick yields exactly one
// transfer on the rsp_ channel with motor drive, latch servo, hotwire enable
// and the phase the sequencer was in during that tick.
// a req_ transfer passes through the input register, then the state machine
// update and the result register. one tick is taken every cycle while the
// receiver does not stall; the rate is set by the registered state update.
// when the receiver stalls, the result register holds and the input register
// still takes one more tick; only when both are full does req_stall rise.
// reset clears both stages, puts the sequencer in the latched phase with a
// zero tick count and loads the default register values. registers are
// written through the apb-style port (pready always high) and are meant to
// change only while no ticks are in flight.
module latch_motor_hotwire_deploy_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [1:0]                req_direction,
   input  logic                             req_cut,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [15:0]               rsp_motor,
   output logic                             rsp_latch,
   output logic                             rsp_hotwire,
   output logic [1:0]                       rsp_phase,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lmhds_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [lmhds_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [lmhds_pkg::DATA_WIDTH-1:0] prdata,
   output logic                             pready
);
   import lmhds_pkg::*;

   cfg_type cfg;

   lmhds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lmhds_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_direction (req_direction),
      .req_cut       (req_cut),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_motor     (rsp_motor),
      .rsp_latch     (rsp_latch),
      .rsp_hotwire   (rsp_hotwire),
      .rsp_phase     (rsp_phase)
   );

endmodule

@@ hdl/lmhds_checker.sv @@
// lmhds_checker: port-level assertions for the deploy sequencer
// depends on lmhds_pkg; bound to latch_motor_hotwire_deploy_sequencer
module lmhds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [15:0]               rsp_motor,
   input logic                             rsp_latch,
   input logic                             rsp_hotwire,
   input logic [1:0]                       rsp_phase,
   input logic                             pready
);
   import lmhds_pkg::*;

   // no result may be showing right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only backs up when the result stage is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // latch is released in every phase past latched
   a_latch_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase != PHASE_LATCHED) |-> !rsp_latch)
      else $error("latch engaged outside latched phase");

   // a stalled result holds its motor drive, hotwire enable and phase
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_motor)
         && $stable(rsp_phase) && $stable(rsp_hotwire)))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind latch_motor_hotwire_deploy_sequencer lmhds_checker u_lmhds_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_motor   (rsp_motor),
   .rsp_latch   (rsp_latch),
   .rsp_hotwire (rsp_hotwire),
   .rsp_phase   (rsp_phase),
   .pready      (pready)
);

@@ verif/latch_motor_hotwire_deploy_sequencer_tb.sv @@
// latch_motor_hotwire_deploy_sequencer_tb: self-checking bench for the deploy sequencer
// drives ticks and register writes, predicts each result and checks them in order
// depends on lmhds_pkg and latch_motor_hotwire_deploy_sequencer
module latch_motor_hotwire_deploy_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmhds_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 1000000;

   localparam logic signed [1:0] DIR_NONE     = 2'sb00;
   localparam logic signed [1:0] DIR_DEPLOY   = 2'sb01;
   localparam logic signed [1:0] DIR_WIDE_NEG = 2'sb10;
   localparam logic signed [1:0] DIR_RETRACT  = 2'sb11;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   typedef struct packed {
      logic signed [15:0] motor;
      logic               latch;
      logic               hotwire;
      logic [1:0]         phase;
   } tick_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [1:0]     req_direction = 2'sb00;
   logic                  req_cut = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_motor;
   logic                  rsp_latch;
   logic                  rsp_hotwire;
   logic [1:0]            rsp_phase;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0] pwdata = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   // sequencer copy kept by the bench
   cfg_type               cfg_copy;
   logic [1:0]            seq_phase;
   logic [TICK_WIDTH-1:0] hold_ticks;

   tick_out_type          pending_ticks[$];
   tick_out_type          head_tick;
   int unsigned           gap_pct = 0;
   int unsigned           stall_pct = 0;
   int unsigned           mismatches = 0;
   int unsigned           cycle_count = 0;

   latch_motor_hotwire_deploy_sequencer u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic tick_out_type predict_tick(logic signed [1:0] dir, logic cut);
      tick_out_type          res;
      logic [1:0]            nxt;
      logic                  fwd;
      logic [TICK_WIDTH-1:0] wait_limit;
      fwd = (dir == DIR_DEPLOY);
      nxt = seq_phase;
      res.motor = cfg_copy.idle_motor;
      res.latch = cfg_copy.idle_latch;
      res.hotwire = cfg_copy.idle_hotwire;
      res.phase = seq_phase;
      case (seq_phase)
         PHASE_LATCHED, PHASE_UNLATCHING: begin
            if (seq_phase == PHASE_LATCHED) begin
               wait_limit = {1'b0, cfg_copy.unlatch_wait_ticks};
            end else begin
               wait_limit = {1'b0, cfg_copy.motor_wait_ticks};
               res.latch = 1'b0;
            end
            // the advancing tick is not counted, the clear on change covers it
            if (!fwd) begin
               hold_ticks = '0;
            end else if (hold_ticks > wait_limit) begin
               nxt = (seq_phase == PHASE_LATCHED) ? PHASE_UNLATCHING : PHASE_MOTOR;
            end else if (hold_ticks != '1) begin
               hold_ticks = hold_ticks + 1'b1;
            end
         end
         PHASE_MOTOR: begin
            res.latch = 1'b0;
            if (cut) begin
               nxt = PHASE_CUT;
            end else if (fwd) begin
               res.motor = {1'b0, cfg_copy.deploy_power};
            end else if (dir[1]) begin
               res.motor = -$signed({1'b0, cfg_copy.deploy_power});
            end
         end
         default: begin
            res.latch = 1'b0;
            if (!cut) begin
               nxt = PHASE_MOTOR;
            end else begin
               res.hotwire = 1'b1;
            end
         end
      endcase
      if (nxt != seq_phase) begin
         hold_ticks = '0;
         seq_phase = nxt;
      end
      return res;
   endfunction

   function automatic logic signed [1:0] pick_non_deploy();
      case ($urandom_range(2))
         0: return DIR_NONE;
         1: return DIR_RETRACT;
         default: return DIR_WIDE_NEG;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ticks.size() == 0) begin
            $display("%0t: result with no tick outstanding, phase %0d", $time, rsp_phase);
            mismatches++;
         end else begin
            head_tick = pending_ticks.pop_front();
            if (rsp_motor !== head_tick.motor) begin
               $display("%0t: motor expected %0d got %0d", $time, head_tick.motor, rsp_motor);
               mismatches++;
            end
            if (rsp_latch !== head_tick.latch) begin
               $display("%0t: latch expected %0d got %0d", $time, head_tick.latch, rsp_latch);
               mismatches++;
            end
            if (rsp_hotwire !== head_tick.hotwire) begin
               $display("%0t: hotwire expected %0d got %0d", $time, head_tick.hotwire,
                        rsp_hotwire);
               mismatches++;
            end
            if (rsp_phase !== head_tick.phase) begin
               $display("%0t: phase expected %0d got %0d", $time, head_tick.phase, rsp_phase);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic set_idling(idling_type mode);
      case (mode)
         IDLE_NONE: begin
            gap_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            gap_pct = 49;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;
            stall_pct = 49;
         end
         default: begin
            gap_pct = 30;
            stall_pct = 30;
         end
      endcase
   endtask

   // valid stays high from one transfer to the next unless a gap is drawn
   task automatic send_tick(logic signed [1:0] dir, logic cut);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_direction <= dir;
      req_cut <= cut;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_ticks.push_back(predict_tick(dir, cut));
   endtask

   task automatic drain_ticks();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [DATA_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_UNLATCH_WAIT: cfg_copy.unlatch_wait_ticks = value[15:0];
         REG_MOTOR_WAIT:   cfg_copy.motor_wait_ticks = value[15:0];
         REG_DEPLOY_POWER: cfg_copy.deploy_power = value[14:0];
         REG_IDLE_MOTOR:   cfg_copy.idle_motor = value[15:0];
         REG_IDLE_LATCH:   cfg_copy.idle_latch = value[0];
         REG_IDLE_HOTWIRE: cfg_copy.idle_hotwire = value[0];
         default: ;
      endcase
   endtask

   task automatic shuffle_idle_outputs();
      write_reg(REG_IDLE_MOTOR, $urandom_range(16'hFFFF));
      write_reg(REG_IDLE_LATCH, $urandom_range(1));
      write_reg(REG_IDLE_HOTWIRE, $urandom_range(1));
   endtask

   // runs of deploy ticks broken by a non-deploy tick, never long enough to advance
   task automatic send_hold_runs(int unsigned wait_ticks, int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      int unsigned longest;
      sent = 0;
      longest = (wait_ticks + 1 < 60) ? wait_ticks + 1 : 60;
      while (sent < count) begin
         run_len = ($urandom_range(2) == 0) ? longest : $urandom_range(longest);
         repeat (run_len) send_tick(DIR_DEPLOY, 1'($urandom_range(1)));
         send_tick(pick_non_deploy(), 1'($urandom_range(1)));
         sent += run_len + 1;
      end
   endtask

   task automatic send_motor_mix(int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      logic        cut_held;
      sent = 0;
      while (sent < count) begin
         cut_held = ($urandom_range(3) == 0);
         run_len = cut_held ? $urandom_range(6, 1) : $urandom_range(10, 1);
         repeat (run_len) send_tick(2'($urandom_range(3)), cut_held);
         sent += run_len;
      end
   endtask

   task automatic test_latched_outputs();
      set_idling(IDLE_NONE);
      send_tick(DIR_DEPLOY, 1'b0);
      send_tick(DIR_DEPLOY, 1'b1);
      send_tick(DIR_NONE, 1'b1);
      send_tick(DIR_DEPLOY, 1'b0);
      send_tick(DIR_RETRACT, 1'b1);
      send_tick(DIR_WIDE_NEG, 1'b0);
      drain_ticks();
      write_reg(REG_IDLE_MOTOR, 32'h0000_8000);
      write_reg(REG_IDLE_LATCH, 32'd0);
      write_reg(REG_IDLE_HOTWIRE, 32'd1);
      send_tick(DIR_WIDE_NEG, 1'b1);
      send_tick(DIR_DEPLOY, 1'b0);
      send_tick(DIR_NONE, 1'b0);
      drain_ticks();
      write_reg(REG_IDLE_MOTOR, 32'h0000_7FFF);
      write_reg(REG_IDLE_LATCH, 32'd1);
      write_reg(REG_IDLE_HOTWIRE, 32'd0);
      send_tick(DIR_RETRACT, 1'b0);
      send_tick(DIR_DEPLOY, 1'b1);
      send_tick(DIR_NONE, 1'b0);
      drain_ticks();
   endtask

   task automatic test_latched_hold();
      int unsigned wait_ticks;
      set_idling(IDLE_SENDER);
      send_hold_runs(32'(cfg_copy.unlatch_wait_ticks), 120);
      drain_ticks();
      write_reg(REG_UNLATCH_WAIT, 32'd0);
      shuffle_idle_outputs();
      set_idling(IDLE_RECEIVER);
      send_hold_runs(0, 120);
      drain_ticks();
      wait_ticks = $urandom_range(25, 1);
      write_reg(REG_UNLATCH_WAIT, wait_ticks);
      shuffle_idle_outputs();
      set_idling(IDLE_BOTH);
      send_hold_runs(wait_ticks, 120);
      drain_ticks();
   endtask

   // one unbroken run just long enough to exceed the threshold and unlatch
   task automatic test_unlatch_advance();
      int unsigned wait_ticks;
      wait_ticks = $urandom_range(40, 1);
      write_reg(REG_UNLATCH_WAIT, wait_ticks);
      set_idling(IDLE_RECEIVER);
      repeat (wait_ticks + 2) send_tick(DIR_DEPLOY, 1'($urandom_range(1)));
      drain_ticks();
   endtask

   task automatic test_unlatching_hold();
      int unsigned wait_ticks;
      wait_ticks = $urandom_range(30, 1);
      write_reg(REG_MOTOR_WAIT, wait_ticks);
      shuffle_idle_outputs();
      set_idling(IDLE_NONE);
      send_hold_runs(wait_ticks, 120);
      drain_ticks();
      write_reg(REG_MOTOR_WAIT, 32'd65535);
      shuffle_idle_outputs();
      set_idling(IDLE_BOTH);
      send_hold_runs(65535, 120);
      drain_ticks();
   endtask

   task automatic test_motor_and_cut();
      write_reg(REG_MOTOR_WAIT, 32'd0);
      write_reg(REG_DEPLOY_POWER, 32'h0000_7FFF);
      write_reg(REG_IDLE_MOTOR, $urandom_range(16'hFFFF));
      write_reg(REG_IDLE_HOTWIRE, 32'd0);
      set_idling(IDLE_NONE);
      send_tick(DIR_DEPLOY, 1'b0);
      send_tick(DIR_DEPLOY, 1'b1);
      send_tick(DIR_DEPLOY, 1'b0);
      send_tick(DIR_RETRACT, 1'b0);
      send_tick(DIR_WIDE_NEG, 1'b0);
      send_tick(DIR_NONE, 1'b0);
      send_tick(DIR_DEPLOY, 1'b1);
      send_tick(DIR_RETRACT, 1'b1);
      send_tick(DIR_NONE, 1'b0);
      drain_ticks();
      write_reg(REG_DEPLOY_POWER, 32'd0);
      send_tick(DIR_RETRACT, 1'b0);
      send_tick(DIR_DEPLOY, 1'b0);
      drain_ticks();
   endtask

   task automatic test_motor_random();
      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0: begin
               write_reg(REG_DEPLOY_POWER, 32'h0000_7FFF);
               write_reg(REG_IDLE_MOTOR, 32'h0000_8000);
            end
            1: begin
               write_reg(REG_DEPLOY_POWER, 32'd0);
               write_reg(REG_IDLE_MOTOR, 32'h0000_7FFF);
            end
            default: begin
               write_reg(REG_DEPLOY_POWER, $urandom_range(15'h7FFF));
               write_reg(REG_IDLE_MOTOR, $urandom_range(16'hFFFF));
            end
         endcase
         write_reg(REG_IDLE_LATCH, $urandom_range(1));
         write_reg(REG_IDLE_HOTWIRE, $urandom_range(1));
         set_idling(idling_type'(pass));
         send_motor_mix(85);
         drain_ticks();
      end
   endtask

   initial begin
      cfg_copy.unlatch_wait_ticks = RST_UNLATCH_WAIT;
      cfg_copy.motor_wait_ticks = RST_MOTOR_WAIT;
      cfg_copy.deploy_power = RST_DEPLOY_POWER;
      cfg_copy.idle_motor = RST_IDLE_MOTOR;
      cfg_copy.idle_latch = RST_IDLE_LATCH;
      cfg_copy.idle_hotwire = RST_IDLE_HOTWIRE;
      seq_phase = PHASE_LATCHED;
      hold_ticks = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // the sequencer never returns to latched, so the order matters
      test_latched_outputs();
      test_latched_hold();
      test_unlatch_advance();
      test_unlatching_hold();
      test_motor_and_cut();
      test_motor_random();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ latch_motor_hotwire_deploy_sequencer.f @@
hdl/lmhds_pkg.sv
hdl/lmhds_csr.sv
hdl/lmhds_core.sv
hdl/latch_motor_hotwire_deploy_sequencer.sv
hdl/lmhds_checker.sv
verif/latch_motor_hotwire_deploy_sequencer_tb.sv
